[hw/rtl/gspid_pkg.sv]
// Shared types and constants for the gain-scheduled PID step core.
// Used by gspid_datapath and gain_scheduled_pid_step_core; no dependencies.
package gspid_pkg;

  // Default values for the top-level parameters.
  localparam int SAMPLE_BITS_DEFAULT    = 12;
  localparam int GAIN_FRAC_BITS_DEFAULT = 8;
  localparam int DRIVE_LIMIT_DEFAULT    = 1000;

  // Each gain is an unsigned 16-bit fixed-point value.
  localparam int GAIN_BITS = 16;

  // Configuration port geometry.
  localparam int CFG_DATA_BITS  = 3 * GAIN_BITS;
  localparam int CFG_INDEX_BITS = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAINS_HIGH  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAINS_MID   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAINS_LOW   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPLIT_UPPER = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPLIT_LOWER = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PROP_ON_MEAS = 3'd5;

  // Command codes carried in the mode field.
  localparam int MODE_BITS = 2;
  localparam logic [MODE_BITS-1:0] MODE_COMPUTE = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_START   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_STOP    = 2'd2;

  // One gain band, laid out as written on the configuration port:
  // kp in bits 15..0, ki in bits 31..16, kd in bits 47..32.
  typedef struct packed {
    logic [GAIN_BITS-1:0] kd;
    logic [GAIN_BITS-1:0] ki;
    logic [GAIN_BITS-1:0] kp;
  } gain_set_t;

endpackage

[hw/rtl/gspid_datapath.sv]
// Single-pass PID arithmetic: band selection, integrator update and drive.
// Depends on gspid_pkg for the gain set type and gain width.
module gspid_datapath #(
  parameter int SAMPLE_BITS    = gspid_pkg::SAMPLE_BITS_DEFAULT,
  parameter int GAIN_FRAC_BITS = gspid_pkg::GAIN_FRAC_BITS_DEFAULT,
  parameter int DRIVE_LIMIT    = gspid_pkg::DRIVE_LIMIT_DEFAULT,
  localparam longint LimitFixed = longint'(DRIVE_LIMIT) <<< GAIN_FRAC_BITS,
  localparam int INTEG_W = $clog2(LimitFixed + 1) + 1,
  localparam int DRIVE_W = $clog2(DRIVE_LIMIT + 1) + 1
) (
  input  logic [SAMPLE_BITS-1:0]     sample,
  input  logic [SAMPLE_BITS-1:0]     setpoint,
  input  logic [SAMPLE_BITS-1:0]     previous_sample,
  input  logic signed [INTEG_W-1:0]  integrator,
  input  gspid_pkg::gain_set_t       gains_high,
  input  gspid_pkg::gain_set_t       gains_mid,
  input  gspid_pkg::gain_set_t       gains_low,
  input  logic [SAMPLE_BITS-1:0]     split_upper,
  input  logic [SAMPLE_BITS-1:0]     split_lower,
  input  logic                       prop_on_measurement,
  output logic signed [INTEG_W-1:0]  integrator_next,
  output logic signed [DRIVE_W-1:0]  drive_value
);

  localparam int ERR_W  = SAMPLE_BITS + 1;
  localparam int PROD_W = gspid_pkg::GAIN_BITS + 1 + ERR_W;
  localparam int SUM_W  = ((PROD_W > INTEG_W) ? PROD_W : INTEG_W) + 2;
  localparam logic signed [SUM_W-1:0] LimHi = SUM_W'(LimitFixed);
  localparam logic signed [SUM_W-1:0] LimLo = -SUM_W'(LimitFixed);

  logic signed [ERR_W-1:0]  error;
  logic signed [ERR_W-1:0]  delta;
  gspid_pkg::gain_set_t     gains;
  logic signed [PROD_W-1:0] kp_err;
  logic signed [PROD_W-1:0] kp_delta;
  logic signed [PROD_W-1:0] ki_err;
  logic signed [PROD_W-1:0] kd_delta;
  logic signed [SUM_W-1:0]  integ_sum;
  logic signed [SUM_W-1:0]  integ_clamped;
  logic signed [SUM_W-1:0]  out_sum;
  logic signed [SUM_W-1:0]  out_clamped;
  logic signed [SUM_W-1:0]  out_floor;

  // Error and measurement change, one bit wider than a sample.
  assign error = $signed({1'b0, setpoint}) - $signed({1'b0, sample});
  assign delta = $signed({1'b0, sample}) - $signed({1'b0, previous_sample});

  // Gain band chosen by the signed error against the two splits.
  always_comb begin
    if (error >= $signed({1'b0, split_upper})) begin
      gains = gains_high;
    end else if (error >= $signed({1'b0, split_lower})) begin
      gains = gains_mid;
    end else begin
      gains = gains_low;
    end
  end

  // Four parallel products; kp is formed on both error and delta.
  assign kp_err   = PROD_W'($signed({1'b0, gains.kp})) * PROD_W'(error);
  assign kp_delta = PROD_W'($signed({1'b0, gains.kp})) * PROD_W'(delta);
  assign ki_err   = PROD_W'($signed({1'b0, gains.ki})) * PROD_W'(error);
  assign kd_delta = PROD_W'($signed({1'b0, gains.kd})) * PROD_W'(delta);

  // Integrator update, with proportional-on-measurement folded in.
  always_comb begin
    integ_sum = SUM_W'(integrator) + SUM_W'(ki_err);
    if (prop_on_measurement) begin
      integ_sum = integ_sum - SUM_W'(kp_delta);
    end
    if (integ_sum > LimHi) begin
      integ_clamped = LimHi;
    end else if (integ_sum < LimLo) begin
      integ_clamped = LimLo;
    end else begin
      integ_clamped = integ_sum;
    end
  end

  assign integrator_next = integ_clamped[INTEG_W-1:0];

  // Output sum, saturated, then floored to integer units.
  always_comb begin
    out_sum = SUM_W'(integrator_next) - SUM_W'(kd_delta);
    if (!prop_on_measurement) begin
      out_sum = out_sum + SUM_W'(kp_err);
    end
    if (out_sum > LimHi) begin
      out_clamped = LimHi;
    end else if (out_sum < LimLo) begin
      out_clamped = LimLo;
    end else begin
      out_clamped = out_sum;
    end
  end

  assign out_floor   = out_clamped >>> GAIN_FRAC_BITS;
  assign drive_value = out_floor[DRIVE_W-1:0];

endmodule

[hw/rtl/gain_scheduled_pid_step_core.sv]
// Top level of the gain-scheduled PID step core: handshakes, state, config.
// Depends on gspid_pkg and gspid_datapath.
//
//   Channel  | Signals                                  | Direction | Beat
//   ---------+------------------------------------------+-----------+---------------------
//   command  | cmd_valid, cmd_ready, mode, sample,      | in        | one control step
//            | setpoint                                 |           |
//   result   | drive_valid, drive_ready, drive          | out       | one drive value
//   config   | cfg_write, cfg_index, cfg_data           | in        | one register write
//
// A command beat is captured in the input stage, evaluated combinationally and
// its drive lands in the output register; one beat is taken per cycle while
// the result side keeps up. The loop through the integrator and previous
// sample sets that rate. A stalled result holds the input stage, which then
// drops cmd_ready. Start beats and unknown modes leave no result. Reset
// clears the valid flags, controller state and configuration.
module gain_scheduled_pid_step_core #(
  parameter int SAMPLE_BITS    = gspid_pkg::SAMPLE_BITS_DEFAULT,
  parameter int GAIN_FRAC_BITS = gspid_pkg::GAIN_FRAC_BITS_DEFAULT,
  parameter int DRIVE_LIMIT    = gspid_pkg::DRIVE_LIMIT_DEFAULT,
  localparam longint LimitFixed = longint'(DRIVE_LIMIT) <<< GAIN_FRAC_BITS,
  localparam int INTEG_W = $clog2(LimitFixed + 1) + 1,
  localparam int DRIVE_W = $clog2(DRIVE_LIMIT + 1) + 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  output logic                                 cmd_ready,
  input  logic [gspid_pkg::MODE_BITS-1:0]      mode,
  input  logic [SAMPLE_BITS-1:0]               sample,
  input  logic [SAMPLE_BITS-1:0]               setpoint,
  output logic                                 drive_valid,
  input  logic                                 drive_ready,
  output logic signed [DRIVE_W-1:0]            drive,
  input  logic                                 cfg_write,
  input  logic [gspid_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [gspid_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam logic signed [INTEG_W-1:0] IntegHi = INTEG_W'(LimitFixed);
  localparam logic signed [INTEG_W-1:0] IntegLo = -INTEG_W'(LimitFixed);
  localparam logic signed [DRIVE_W-1:0] DriveHi = DRIVE_W'(DRIVE_LIMIT);
  localparam logic signed [DRIVE_W-1:0] DriveLo = -DRIVE_W'(DRIVE_LIMIT);

  // Configuration registers.
  gspid_pkg::gain_set_t   gains_high;
  gspid_pkg::gain_set_t   gains_mid;
  gspid_pkg::gain_set_t   gains_low;
  logic [SAMPLE_BITS-1:0] split_upper;
  logic [SAMPLE_BITS-1:0] split_lower;
  logic                   prop_on_measurement;

  // Controller state.
  logic [SAMPLE_BITS-1:0]    previous_sample;
  logic signed [INTEG_W-1:0] integrator;

  // Input stage.
  logic                            stage_valid;
  logic [gspid_pkg::MODE_BITS-1:0] stage_mode;
  logic [SAMPLE_BITS-1:0]          stage_sample;
  logic [SAMPLE_BITS-1:0]          stage_setpoint;

  logic                      stage_has_result;
  logic                      stage_fire;
  logic                      out_free;
  logic signed [INTEG_W-1:0] integrator_next;
  logic signed [DRIVE_W-1:0] drive_value;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      gains_high          <= '0;
      gains_mid           <= '0;
      gains_low           <= '0;
      split_upper         <= '0;
      split_lower         <= '0;
      prop_on_measurement <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gspid_pkg::REG_GAINS_HIGH:   gains_high <= gspid_pkg::gain_set_t'(cfg_data);
        gspid_pkg::REG_GAINS_MID:    gains_mid  <= gspid_pkg::gain_set_t'(cfg_data);
        gspid_pkg::REG_GAINS_LOW:    gains_low  <= gspid_pkg::gain_set_t'(cfg_data);
        gspid_pkg::REG_SPLIT_UPPER:  split_upper <= cfg_data[SAMPLE_BITS-1:0];
        gspid_pkg::REG_SPLIT_LOWER:  split_lower <= cfg_data[SAMPLE_BITS-1:0];
        gspid_pkg::REG_PROP_ON_MEAS: prop_on_measurement <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake: the stage moves on when its result, if any, has a free slot.
  assign stage_has_result = (stage_mode == gspid_pkg::MODE_COMPUTE) ||
                            (stage_mode == gspid_pkg::MODE_STOP);
  assign out_free   = !drive_valid || drive_ready;
  assign stage_fire = stage_valid && (!stage_has_result || out_free);
  assign cmd_ready  = !stage_valid || stage_fire;

  // Input stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd_ready) begin
      stage_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      stage_mode     <= mode;
      stage_sample   <= sample;
      stage_setpoint <= setpoint;
    end
  end

  gspid_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .DRIVE_LIMIT    (DRIVE_LIMIT)
  ) u_datapath (
    .sample              (stage_sample),
    .setpoint            (stage_setpoint),
    .previous_sample     (previous_sample),
    .integrator          (integrator),
    .gains_high          (gains_high),
    .gains_mid           (gains_mid),
    .gains_low           (gains_low),
    .split_upper         (split_upper),
    .split_lower         (split_lower),
    .prop_on_measurement (prop_on_measurement),
    .integrator_next     (integrator_next),
    .drive_value         (drive_value)
  );

  // Controller state commits when the staged beat leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      integrator      <= '0;
    end else if (stage_fire) begin
      case (stage_mode)
        gspid_pkg::MODE_COMPUTE: begin
          previous_sample <= stage_sample;
          integrator      <= integrator_next;
        end
        gspid_pkg::MODE_START: begin
          previous_sample <= stage_sample;
          integrator      <= '0;
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (out_free) begin
      drive_valid <= stage_fire && stage_has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && stage_has_result) begin
      drive <= (stage_mode == gspid_pkg::MODE_STOP) ? '0 : drive_value;
    end
  end

  // A stop beat always answers with a zero drive in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (stage_fire && stage_mode == gspid_pkg::MODE_STOP) |=> (drive_valid && drive == '0))
    else $error("stop beat did not produce a zero drive");

  // A start beat clears the integrator and primes the previous sample.
  assert property (@(posedge clk) disable iff (rst)
    (stage_fire && stage_mode == gspid_pkg::MODE_START)
      |=> (integrator == '0 && previous_sample == $past(stage_sample)))
    else $error("start beat did not prime the controller state");

  // The integrator stays within the saturation limits.
  assert property (@(posedge clk) disable iff (rst)
    (integrator <= IntegHi && integrator >= IntegLo))
    else $error("integrator outside its saturation limits");

  // A delivered drive value stays within the drive limits.
  assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> (drive <= DriveHi && drive >= DriveLo))
    else $error("drive value outside its limits");

endmodule

[dv/gain_scheduled_pid_step_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for gain_scheduled_pid_step_core: a drive predictor
// in a scoreboard class checks every drive beat. Depends on gspid_pkg and the RTL.
module gain_scheduled_pid_step_core_tb;

  localparam int SMP_W = 12;
  localparam int DRIVE_W = 11;
  localparam int FRAC = 8;
  localparam longint LIMIT_FX = longint'(1000) <<< FRAC;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [gspid_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [gspid_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_7 = 3'd7;
  // Mode code with no meaning; the block drops such beats.
  localparam logic [gspid_pkg::MODE_BITS-1:0] MODE_UNUSED = 2'd3;

  // Scoreboard: keeps its own copy of configuration and loop state and the
  // queue of drive values still owed by the block.
  class pid_drive_scoreboard;
    gspid_pkg::gain_set_t band_high, band_mid, band_low;
    logic [SMP_W-1:0] split_upper, split_lower;
    logic prop_on_meas;
    logic [SMP_W-1:0] prev_sample;
    longint integ;
    logic signed [DRIVE_W-1:0] drive_expected[$];
    int errors;

    function new();
      band_high = '0;
      band_mid = '0;
      band_low = '0;
      split_upper = '0;
      split_lower = '0;
      prop_on_meas = 1'b0;
      prev_sample = '0;
      integ = 0;
      errors = 0;
    endfunction

    function longint saturate(longint v);
      if (v > LIMIT_FX) return LIMIT_FX;
      if (v < -LIMIT_FX) return -LIMIT_FX;
      return v;
    endfunction

    function void note_reg_write(logic [gspid_pkg::CFG_INDEX_BITS-1:0] idx,
                                 logic [gspid_pkg::CFG_DATA_BITS-1:0] data);
      case (idx)
        gspid_pkg::REG_GAINS_HIGH: band_high = data;
        gspid_pkg::REG_GAINS_MID: band_mid = data;
        gspid_pkg::REG_GAINS_LOW: band_low = data;
        gspid_pkg::REG_SPLIT_UPPER: split_upper = data[SMP_W-1:0];
        gspid_pkg::REG_SPLIT_LOWER: split_lower = data[SMP_W-1:0];
        gspid_pkg::REG_PROP_ON_MEAS: prop_on_meas = data[0];
        default: ;
      endcase
    endfunction

    // Work out the drive owed for one accepted command beat.
    function void note_command(logic [gspid_pkg::MODE_BITS-1:0] m, logic [SMP_W-1:0] s,
                               logic [SMP_W-1:0] sp);
      longint err, delta, kp, ki, kd, sum;
      gspid_pkg::gain_set_t g;
      logic signed [DRIVE_W-1:0] d;
      case (m)
        gspid_pkg::MODE_START: begin
          prev_sample = s;
          integ = 0;
        end
        gspid_pkg::MODE_STOP: drive_expected.push_back('0);
        gspid_pkg::MODE_COMPUTE: begin
          err = longint'(sp) - longint'(s);
          delta = longint'(s) - longint'(prev_sample);
          // Band choice: the upper split wins, then the lower one.
          if (err >= longint'(split_upper)) g = band_high;
          else if (err >= longint'(split_lower)) g = band_mid;
          else g = band_low;
          kp = longint'(g.kp);
          ki = longint'(g.ki);
          kd = longint'(g.kd);
          integ = integ + ki * err;
          if (prop_on_meas) integ = integ - kp * delta;
          integ = saturate(integ);
          sum = prop_on_meas ? 0 : kp * err;
          sum = saturate(sum + integ - kd * delta);
          prev_sample = s;
          d = DRIVE_W'(sum >>> FRAC);
          drive_expected.push_back(d);
        end
        default: ;
      endcase
    endfunction

    function void check_drive(logic signed [DRIVE_W-1:0] actual);
      logic signed [DRIVE_W-1:0] exp_drive;
      if (drive_expected.size() == 0) begin
        $error("drive beat with nothing expected: actual %0d", actual);
        errors++;
        return;
      end
      exp_drive = drive_expected.pop_front();
      if (actual !== exp_drive) begin
        $error("drive mismatch: expected %0d, actual %0d", exp_drive, actual);
        errors++;
      end
    endfunction

    function int pending();
      return drive_expected.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  logic [gspid_pkg::MODE_BITS-1:0] mode = gspid_pkg::MODE_COMPUTE;
  logic [SMP_W-1:0] sample = '0;
  logic [SMP_W-1:0] setpoint = '0;
  logic drive_valid;
  logic drive_ready = 1'b0;
  logic signed [DRIVE_W-1:0] drive;
  logic cfg_write = 1'b0;
  logic [gspid_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [gspid_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  pid_drive_scoreboard sb = new();
  int cycle_count;
  int ready_run = 0;
  logic ready_level = 1'b0;

  gain_scheduled_pid_step_core DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .mode(mode),
    .sample(sample),
    .setpoint(setpoint),
    .drive_valid(drive_valid),
    .drive_ready(drive_ready),
    .drive(drive),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each accepted beat, and stall in runs of random
  // length with occasional long stretches of steady ready.
  always @(posedge clk) begin
    if (!rst && drive_valid && drive_ready) sb.check_drive(drive);
    if (ready_run == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        ready_level = 1'b1;
        ready_run = $urandom_range(20, 60);
      end else if (ready_level) begin
        ready_level = 1'b0;
        ready_run = $urandom_range(1, 8);
      end else begin
        ready_level = 1'b1;
        ready_run = $urandom_range(1, 6);
      end
    end else begin
      ready_run--;
    end
    drive_ready <= ready_level;
  end

  // Watchdog on the cycle count.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Hold a command beat until it is taken, then book it with the scoreboard.
  task automatic send_cmd(logic [gspid_pkg::MODE_BITS-1:0] m, logic [SMP_W-1:0] s,
                          logic [SMP_W-1:0] sp);
    cmd_valid <= 1'b1;
    mode <= m;
    sample <= s;
    setpoint <= sp;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    sb.note_command(m, s, sp);
  endtask

  // Stop sending and wait until the block has nothing left in flight.
  task automatic drain_results();
    cmd_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [gspid_pkg::CFG_INDEX_BITS-1:0] idx,
                           logic [gspid_pkg::CFG_DATA_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.note_reg_write(idx, data);
  endtask

  // Write every register; the narrow ones carry random upper bits that the
  // block has to drop, and the spare indexes get junk that must be ignored.
  task automatic load_config(logic [47:0] hi, logic [47:0] mid, logic [47:0] lo,
                             logic [SMP_W-1:0] su, logic [SMP_W-1:0] sl, logic pom);
    logic [47:0] junk;
    junk = 48'({$urandom, $urandom});
    write_reg(gspid_pkg::REG_GAINS_HIGH, hi);
    write_reg(gspid_pkg::REG_GAINS_MID, mid);
    write_reg(gspid_pkg::REG_GAINS_LOW, lo);
    write_reg(gspid_pkg::REG_SPLIT_UPPER, {junk[47:SMP_W], su});
    junk = 48'({$urandom, $urandom});
    write_reg(gspid_pkg::REG_SPLIT_LOWER, {junk[47:SMP_W], sl});
    junk = 48'({$urandom, $urandom});
    write_reg(gspid_pkg::REG_PROP_ON_MEAS, {junk[47:1], pom});
    write_reg(REG_SPARE_6, 48'({$urandom, $urandom}));
    write_reg(REG_SPARE_7, 48'({$urandom, $urandom}));
    cfg_write <= 1'b0;
  endtask

  // Gains small enough that the loop does not pin to its limits at once.
  function automatic logic [47:0] mild_gains();
    logic [15:0] kp, ki, kd;
    kp = 16'($urandom_range(0, 16'h0400));
    ki = 16'($urandom_range(0, 16'h0040));
    kd = 16'($urandom_range(0, 16'h0200));
    return {kd, ki, kp};
  endfunction

  // Mostly start / compute runs that track a target, plus noise beats.
  task automatic run_random(int count);
    int left, burst_left, gap, seq_left, r, p, jitter;
    logic [SMP_W-1:0] pos, tgt, s, sp;
    logic [gspid_pkg::MODE_BITS-1:0] m;
    left = count;
    burst_left = 0;
    seq_left = 0;
    pos = 12'($urandom);
    tgt = 12'($urandom);
    while (left > 0) begin
      // Sender idling: bursts with gaps, and now and then a full drain.
      if ($urandom_range(0, 149) == 0) begin
        drain_results();
        burst_left = $urandom_range(1, 24);
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          cmd_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;

      r = $urandom_range(0, 99);
      if (seq_left == 0) begin
        if (r < 80) begin
          pos = 12'($urandom);
          if ($urandom_range(0, 1) == 0) begin
            tgt = 12'($urandom);
          end else begin
            p = int'(pos) + $urandom_range(0, 600) - 300;
            tgt = (p < 0) ? 12'd0 : (p > 4095) ? 12'd4095 : 12'(p);
          end
          m = gspid_pkg::MODE_START;
          s = pos;
          sp = tgt;
          seq_left = $urandom_range(4, 30);
        end else begin
          m = 2'($urandom_range(0, 3));
          s = 12'($urandom);
          sp = 12'($urandom);
        end
      end else begin
        seq_left--;
        if (r < 5) begin
          m = gspid_pkg::MODE_STOP;
        end else begin
          m = gspid_pkg::MODE_COMPUTE;
          if (r < 10) tgt = 12'($urandom);
          if (r < 13) begin
            pos = 12'($urandom);
          end else begin
            jitter = $urandom_range(0, 40);
            p = int'(pos) + (int'(tgt) - int'(pos)) / 4 + jitter - 20;
            pos = (p < 0) ? 12'd0 : (p > 4095) ? 12'd4095 : 12'(p);
          end
        end
        s = pos;
        sp = tgt;
      end
      send_cmd(m, s, sp);
      if (m != MODE_UNUSED) left--;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Compute right after reset: reset previous sample, all gains zero.
    send_cmd(gspid_pkg::MODE_COMPUTE, 12'd100, 12'd3000);
    drain_results();

    // Directed: band edges, field extremes, every mode, ignored mode.
    load_config({16'h0100, 16'h0020, 16'h0200}, {16'h0080, 16'h0010, 16'h0100},
                {16'h0040, 16'h0008, 16'h0080}, 12'd200, 12'd0, 1'b0);
    send_cmd(gspid_pkg::MODE_COMPUTE, 12'd4095, 12'd0);
    send_cmd(gspid_pkg::MODE_COMPUTE, 12'd0, 12'd4095);
    send_cmd(gspid_pkg::MODE_STOP, 12'd4095, 12'd4095);
    send_cmd(MODE_UNUSED, 12'd1234, 12'd2345);
    send_cmd(gspid_pkg::MODE_START, 12'd2048, 12'd0);
    send_cmd(gspid_pkg::MODE_COMPUTE, 12'd2048, 12'd2048);
    send_cmd(gspid_pkg::MODE_COMPUTE, 12'd2048, 12'd2248);
    send_cmd(gspid_pkg::MODE_COMPUTE, 12'd2048, 12'd2247);
    send_cmd(gspid_pkg::MODE_COMPUTE, 12'd2048, 12'd2047);
    send_cmd(gspid_pkg::MODE_COMPUTE, 12'd2000, 12'd2000);
    send_cmd(gspid_pkg::MODE_STOP, 12'd0, 12'd0);
    send_cmd(gspid_pkg::MODE_START, 12'd0, 12'd4095);
    send_cmd(gspid_pkg::MODE_COMPUTE, 12'd4095, 12'd4095);
    drain_results();

    // Directed: full-scale gains, lower split above the upper one,
    // proportional action on measurement.
    load_config({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, 12'd10, 12'd3000, 1'b1);
    send_cmd(gspid_pkg::MODE_START, 12'd1000, 12'd1000);
    send_cmd(gspid_pkg::MODE_COMPUTE, 12'd1000, 12'd1005);
    send_cmd(gspid_pkg::MODE_COMPUTE, 12'd1000, 12'd1010);
    send_cmd(gspid_pkg::MODE_COMPUTE, 12'd1100, 12'd0);
    send_cmd(gspid_pkg::MODE_COMPUTE, 12'd0, 12'd0);
    send_cmd(gspid_pkg::MODE_STOP, 12'd2222, 12'd1111);
    send_cmd(gspid_pkg::MODE_START, 12'd4095, 12'd0);
    send_cmd(gspid_pkg::MODE_COMPUTE, 12'd0, 12'd4095);

    // Random phases, each under its own configuration.
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0: load_config(mild_gains(), mild_gains(), mild_gains(),
                       12'($urandom_range(100, 300)), 12'($urandom_range(0, 99)), 1'b0);
        1: load_config(mild_gains(), mild_gains(), mild_gains(),
                       12'($urandom_range(100, 300)), 12'($urandom_range(0, 99)), 1'b1);
        2: load_config({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, 12'd4095, 12'd0, 1'b0);
        3: load_config('0, '0, '0, 12'd0, 12'd0, 1'b1);
        4: load_config(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                       48'({$urandom, $urandom}),
                       12'($urandom_range(0, 200)), 12'($urandom_range(200, 4095)),
                       1'($urandom_range(0, 1)));
        default: load_config(mild_gains(), mild_gains(), mild_gains(),
                             12'd0, 12'd4095, 1'b0);
      endcase
      run_random(150);
    end

    // Let the last beats land, then report.
    drain_results();
    repeat (6) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
